@@ src/motor_deadband_sweep_sequencer_unit_assert.svh @@
`ifndef MOTOR_DEADBAND_SWEEP_SEQUENCER_UNIT_ASSERT_SVH
`define MOTOR_DEADBAND_SWEEP_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MDSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdss same-cycle check failed");

// next-cycle implication, checked outside reset
`define MDSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdss next-cycle check failed");

`endif

@@ src/mdss_pkg.sv @@
package mdss_pkg;

    localparam int TABLE_STEPS_DEFAULT = 7;
    localparam int COUNT_BITS_DEFAULT  = 32;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_TICKS     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_COUNT     = 2'd2;

    localparam logic [3:0]  DEBOUNCE_TICKS_RESET = 4'd6;
    localparam logic [15:0] STEP_TICKS_RESET     = 16'd100;
    localparam logic [2:0]  STEP_COUNT_RESET     = 3'd7;

    localparam logic [15:0] TICK_SATURATE = 16'hFFFF;

    typedef logic [6:0] duty_t;

    function automatic duty_t duty_lookup(input logic [2:0] idx);
        duty_t d;
        case (idx)
            3'd0:    d = 7'd20;
            3'd1:    d = 7'd30;
            3'd2:    d = 7'd40;
            3'd3:    d = 7'd50;
            3'd4:    d = 7'd60;
            3'd5:    d = 7'd80;
            default: d = 7'd100;
        endcase
        return d;
    endfunction

endpackage

@@ src/motor_deadband_sweep_sequencer_unit.sv @@
// An accepted input transaction is held in the input registers; its result is registered when that stage advances.
// Throughput: one transaction per cycle while the output side does not stall.
// The per-tick state update is combinational between the input and result registers.
// Reset (rst_n low, asynchronous): sweep idle, debouncer released, registers at defaults.
`include "motor_deadband_sweep_sequencer_unit_assert.svh"

module motor_deadband_sweep_sequencer_unit
    import mdss_pkg::*;
#(
    parameter int TABLE_STEPS = TABLE_STEPS_DEFAULT,
    parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          button_level,
    input  logic signed [COUNT_BITS-1:0]  left_pos,
    input  logic signed [COUNT_BITS-1:0]  right_pos,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          running,
    output logic                          finished,
    output logic [2:0]                    stage_index,
    output logic [6:0]                    duty_permille,
    output logic                          record_valid,
    output logic [2:0]                    record_stage,
    output logic signed [COUNT_BITS-1:0]  left_delta,
    output logic signed [COUNT_BITS-1:0]  right_delta
);

    localparam logic [3:0] TableLimit = 4'(TABLE_STEPS);

    logic [3:0]  debounce_ticks_reg;
    logic [15:0] step_ticks_reg;
    logic [2:0]  step_count_reg;

    logic                   s0_valid_reg;
    logic                   level_reg;
    logic [COUNT_BITS-1:0]  lc_reg;
    logic [COUNT_BITS-1:0]  rc_reg;

    logic                   stable_reg, stable_next;
    logic                   cand_reg, cand_next;
    logic [3:0]             dcount_reg, dcount_next;
    logic [15:0]            tick_reg, tick_next;
    logic [2:0]             stage_reg, stage_next;
    logic                   active_reg, active_next;
    logic                   done_reg, done_next;
    logic [COUNT_BITS-1:0]  lstart_reg, lstart_next;
    logic [COUNT_BITS-1:0]  rstart_reg, rstart_next;

    logic                   out_valid_reg;
    logic                   running_reg;
    logic                   finished_reg;
    logic [2:0]             stage_out_reg;
    logic [6:0]             duty_reg, duty_next;
    logic                   rec_reg, rec_next;
    logic [2:0]             rec_stage_reg, rec_stage_next;
    logic [COUNT_BITS-1:0]  ldelta_reg, ldelta_next;
    logic [COUNT_BITS-1:0]  rdelta_reg, rdelta_next;

    logic        advance;
    logic        in_accept;
    logic        release_evt;
    logic [15:0] tick_inc;
    logic [2:0]  stage_inc;
    logic [3:0]  stage_limit;

    assign advance   = s0_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s0_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_TICKS_RESET;
            step_ticks_reg     <= STEP_TICKS_RESET;
            step_count_reg     <= STEP_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[3:0];
                REG_STEP_TICKS:     step_ticks_reg     <= cfg_data[15:0];
                REG_STEP_COUNT:     step_count_reg     <= cfg_data[2:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            level_reg <= button_level;
            lc_reg    <= left_pos;
            rc_reg    <= right_pos;
        end
    end

    always_comb
    begin
        stable_next  = stable_reg;
        cand_next    = cand_reg;
        dcount_next  = dcount_reg;
        release_evt  = 1'b0;
        if (level_reg != cand_reg)
        begin
            cand_next   = level_reg;
            dcount_next = 4'd1;
        end
        else if (dcount_reg < debounce_ticks_reg)
        begin
            dcount_next = dcount_reg + 4'd1;
        end
        else if (stable_reg != cand_reg)
        begin
            stable_next = cand_reg;
            release_evt = stable_reg && !cand_reg;
        end
    end

    assign tick_inc    = (tick_reg == TICK_SATURATE) ? tick_reg : tick_reg + 16'd1;
    assign stage_inc   = stage_reg + 3'd1;
    assign stage_limit = ({1'b0, step_count_reg} > TableLimit) ? TableLimit
                                                               : {1'b0, step_count_reg};

    always_comb
    begin
        tick_next      = tick_reg;
        stage_next     = stage_reg;
        active_next    = active_reg;
        done_next      = done_reg;
        lstart_next    = lstart_reg;
        rstart_next    = rstart_reg;
        rec_next       = 1'b0;
        rec_stage_next = 3'd0;
        ldelta_next    = '0;
        rdelta_next    = '0;
        if (active_reg)
        begin
            if (release_evt)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                tick_next = tick_inc;
                if (tick_inc >= step_ticks_reg)
                begin
                    rec_next       = 1'b1;
                    rec_stage_next = stage_reg;
                    ldelta_next    = lc_reg - lstart_reg;
                    rdelta_next    = rc_reg - rstart_reg;
                    stage_next     = stage_inc;
                    if ({1'b0, stage_inc} >= stage_limit)
                    begin
                        active_next = 1'b0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        lstart_next = lc_reg;
                        rstart_next = rc_reg;
                        tick_next   = 16'd0;
                    end
                end
            end
        end
        else if (release_evt)
        begin
            stage_next  = 3'd0;
            done_next   = 1'b0;
            active_next = 1'b1;
            lstart_next = lc_reg;
            rstart_next = rc_reg;
            tick_next   = 16'd0;
        end
        duty_next = active_next ? duty_lookup(stage_next) : 7'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            cand_reg   <= 1'b0;
            dcount_reg <= 4'd0;
            tick_reg   <= 16'd0;
            stage_reg  <= 3'd0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            lstart_reg <= '0;
            rstart_reg <= '0;
        end
        else if (advance)
        begin
            stable_reg <= stable_next;
            cand_reg   <= cand_next;
            dcount_reg <= dcount_next;
            tick_reg   <= tick_next;
            stage_reg  <= stage_next;
            active_reg <= active_next;
            done_reg   <= done_next;
            lstart_reg <= lstart_next;
            rstart_reg <= rstart_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            running_reg   <= active_next;
            finished_reg  <= done_next;
            stage_out_reg <= stage_next;
            duty_reg      <= duty_next;
            rec_reg       <= rec_next;
            rec_stage_reg <= rec_stage_next;
            ldelta_reg    <= ldelta_next;
            rdelta_reg    <= rdelta_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign running       = running_reg;
    assign finished      = finished_reg;
    assign stage_index   = stage_out_reg;
    assign duty_permille = duty_reg;
    assign record_valid  = rec_reg;
    assign record_stage  = rec_stage_reg;
    assign left_delta    = ldelta_reg;
    assign right_delta   = rdelta_reg;

    `MDSS_ASSERT_NOW(a_run_done_exclusive, active_reg, !done_reg)
    `MDSS_ASSERT_NOW(a_duty_tracks_run, out_valid_reg, running_reg == (duty_reg != 7'd0))
    `MDSS_ASSERT_NOW(a_last_record_finishes, out_valid_reg && rec_reg && !running_reg, finished_reg)
    `MDSS_ASSERT_NOW(a_idle_deltas_zero, out_valid_reg && !rec_reg,
                     ldelta_reg == '0 && rdelta_reg == '0 && rec_stage_reg == 3'd0)
    `MDSS_ASSERT_NEXT(a_advance_presents, advance, out_valid_reg)

endmodule
